/* design/lpfd_pkg.sv */
package lpfd_pkg;

  localparam int unsigned HDR_BYTES        = 10;
  localparam int unsigned CHECK_AT         = 6;
  localparam int unsigned FILL_W           = 4;
  localparam int unsigned DEF_MAX_FRAME    = 65536;
  localparam int unsigned CFG_IDX_W        = 4;
  localparam int unsigned CFG_DATA_W       = 8;
  localparam int unsigned ID_W             = 32;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_DROP    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CAUSE_MAGIC   = 2'd0,
    CAUSE_VERSION = 2'd1,
    CAUSE_LENGTH  = 2'd2
  } cause_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAGIC   = 4'd0,
    REG_VERSION = 4'd1
  } reg_idx_e;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       data;
    logic [ID_W-1:0]  id;
    logic             last;
    cause_e           cause;
  } res_t;

endpackage

/* design/lpfd_if.sv */
interface lpfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [31:0] request_id;
  logic        frame_end;
  logic [1:0]  drop_cause;

  modport source (output valid, output result_kind, output payload_byte,
                  output request_id, output frame_end, output drop_cause,
                  input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input request_id, input frame_end, input drop_cause,
                  output ready);
endinterface

/* design/lpfd_core.sv */
module lpfd_core
  import lpfd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  acc_i,
  input  logic [7:0]            byte_i,
  output logic                  res_valid_o,
  output res_t                  res_o
);

  localparam int unsigned PL_SPAN = MAX_FRAME_BYTES - HDR_BYTES + 1;
  localparam int unsigned PL_W    = (PL_SPAN > 1) ? $clog2(PL_SPAN) : 1;

  logic [7:0]        magic_q, version_q;
  logic [7:0]        win_q [HDR_BYTES];
  logic [7:0]        win_d [HDR_BYTES];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              in_payload_q, in_payload_d;
  logic [PL_W-1:0]   left_q, left_d;
  logic [ID_W-1:0]   rid_q, rid_d;
  logic [31:0]       len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= '0;
      version_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_MAGIC)   magic_q   <= cfg_wdata_i;
      if (cfg_idx_i == REG_VERSION) version_q <= cfg_wdata_i;
    end
  end

  assign len = {win_q[0], win_q[1], win_q[2], win_q[3]};

  always_comb begin
    win_d        = win_q;
    fill_d       = fill_q;
    in_payload_d = in_payload_q;
    left_d       = left_q;
    rid_d        = rid_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    if (acc_i) begin
      if (in_payload_q) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_PAYLOAD;
        res_o.data  = byte_i;
        res_o.id    = rid_q;
        res_o.last  = (left_q <= PL_W'(1));
        if (left_q != '0) left_d = left_q - PL_W'(1);
        if (left_q <= PL_W'(1)) in_payload_d = 1'b0;
      end else begin
        win_d[fill_q] = byte_i;
        fill_d        = fill_q + FILL_W'(1);
        if (fill_q == FILL_W'(CHECK_AT - 1)) begin
          // check in order: magic, version, length
          if (win_q[4] != magic_q) begin
            res_valid_o = 1'b1;
            res_o.cause = CAUSE_MAGIC;
          end else if (byte_i != version_q) begin
            res_valid_o = 1'b1;
            res_o.cause = CAUSE_VERSION;
          end else if (len < HDR_BYTES || len > MAX_FRAME_BYTES) begin
            res_valid_o = 1'b1;
            res_o.cause = CAUSE_LENGTH;
          end
          if (res_valid_o) begin
            // drop the oldest byte, keep the other five
            res_o.kind = KIND_DROP;
            win_d[0]   = win_q[1];
            win_d[1]   = win_q[2];
            win_d[2]   = win_q[3];
            win_d[3]   = win_q[4];
            win_d[4]   = byte_i;
            win_d[5]   = '0;
            fill_d     = FILL_W'(CHECK_AT - 1);
          end
        end else if (fill_q == FILL_W'(HDR_BYTES - 1)) begin
          rid_d  = {win_q[6], win_q[7], win_q[8], byte_i};
          fill_d = '0;
          if (len <= HDR_BYTES) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_EMPTY;
            res_o.id    = rid_d;
            res_o.last  = 1'b1;
          end else begin
            left_d       = PL_W'(len - HDR_BYTES);
            in_payload_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      in_payload_q <= 1'b0;
      left_q       <= '0;
      rid_q        <= '0;
    end else begin
      fill_q       <= fill_d;
      in_payload_q <= in_payload_d;
      left_q       <= left_d;
      rid_q        <= rid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (left_q != '0))
    else $error("payload mode with nothing left");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < FILL_W'(HDR_BYTES))
    else $error("header fill out of range");

  a_payload_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_payload_q) |-> ($past(left_q) == PL_W'(1)))
    else $error("left payload mode early");

endmodule

/* design/lpfd_out_buf.sv */
module lpfd_out_buf
  import lpfd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic space_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t data_o
);

  res_t       ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign space_o = (cnt_q != 2'd2);
  assign pop     = valid_o && ready_i;
  assign data_o  = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop)    rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (space_o || pop))
    else $error("push into full buffer");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("buffer count out of range");

  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wr_q != rd_q))
    else $error("pointers disagree with count");

endmodule

/* design/length_prefixed_frame_deframer.sv */
// Length-prefixed frame deframer. Takes one stream byte per cycle while rx.ready
// is high, with no bubbles: every byte is processed in the cycle it is accepted
// and its result (if any) is registered in the output buffer. A two-entry
// output buffer parts the two sides, so rx.ready drops only when both entries
// hold results the sink has not taken yet. Outside a frame the block collects a
// 10-byte header (length, magic, version, request id). Magic, version and length
// are checked when byte six arrives; a failure drops the oldest byte and reports
// the cause (resync one byte at a time). A good header is followed by the
// payload bytes, each tagged with the request id, the last one marked with
// frame_end; a frame of header only gives one empty-frame marker. Write
// magic_value (index 0) and version_value (index 1) only while idle.
module length_prefixed_frame_deframer
  import lpfd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  lpfd_byte_if.sink             rx,
  lpfd_result_if.source         res
);

  logic acc;
  logic core_valid;
  res_t core_res;
  res_t buf_res;
  logic buf_space;

  // accept whenever the output buffer can take a result
  assign rx.ready = buf_space;
  assign acc      = rx.valid && rx.ready;

  lpfd_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .byte_i      (rx.rx_byte),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  // hold results until the sink takes the transaction
  lpfd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (core_valid),
    .data_i  (core_res),
    .space_o (buf_space),
    .valid_o (res.valid),
    .ready_i (res.ready),
    .data_o  (buf_res)
  );

  assign res.result_kind  = buf_res.kind;
  assign res.payload_byte = buf_res.data;
  assign res.request_id   = buf_res.id;
  assign res.frame_end    = buf_res.last;
  assign res.drop_cause   = buf_res.cause;

endmodule

/* verif/lpfd_deframe_check.sv */
module lpfd_deframe_check
  import lpfd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  lpfd_byte_if                  rx,
  lpfd_result_if                res,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o,
  output int unsigned           result_count_o,
  output int unsigned           drop_count_o,
  output int unsigned           end_count_o
);

  // Own copy of the deframer state and registers
  logic [7:0]        hdr_win [HDR_BYTES];
  logic [FILL_W-1:0] hdr_fill;
  logic              in_frame;
  logic [31:0]       bytes_left;
  logic [ID_W-1:0]   frame_id;
  logic [7:0]        magic_q;
  logic [7:0]        version_q;

  res_t        deframed_q [$];
  res_t        want;
  int unsigned n_fail;
  int unsigned n_results;
  int unsigned n_drops;
  int unsigned n_ends;

  task automatic deframe_byte(input logic [7:0] b);
    logic [31:0] hdr_len;
    res_t        r;
    logic        bad;
    cause_e      why;
    int          i;
    r   = '{kind: KIND_PAYLOAD, data: '0, id: '0, last: 1'b0, cause: CAUSE_MAGIC};
    bad = 1'b1;
    why = CAUSE_MAGIC;
    if (in_frame) begin
      r.data = b;
      r.id   = frame_id;
      r.last = (bytes_left <= 1);
      if (bytes_left > 0) bytes_left--;
      if (bytes_left == 0) in_frame = 1'b0;
      deframed_q = {deframed_q, r};
    end else begin
      if (hdr_fill >= HDR_BYTES) hdr_fill = '0;
      hdr_win[hdr_fill] = b;
      hdr_fill++;
      hdr_len = {hdr_win[0], hdr_win[1], hdr_win[2], hdr_win[3]};
      if (hdr_fill == CHECK_AT) begin
        // First failing check wins: magic, then version, then length
        if (hdr_win[4] != magic_q) why = CAUSE_MAGIC;
        else if (hdr_win[5] != version_q) why = CAUSE_VERSION;
        else if (hdr_len < HDR_BYTES || hdr_len > MAX_FRAME_BYTES) why = CAUSE_LENGTH;
        else bad = 1'b0;
        if (bad) begin
          // Drop the oldest byte, keep the other five
          for (i = 0; i < CHECK_AT - 1; i++) hdr_win[i] = hdr_win[i + 1];
          hdr_win[CHECK_AT - 1] = '0;
          hdr_fill = FILL_W'(CHECK_AT - 1);
          r.kind  = KIND_DROP;
          r.cause = why;
          deframed_q = {deframed_q, r};
        end
      end else if (hdr_fill == HDR_BYTES) begin
        frame_id = {hdr_win[6], hdr_win[7], hdr_win[8], hdr_win[9]};
        hdr_fill = '0;
        if (hdr_len <= HDR_BYTES) begin
          r.kind = KIND_EMPTY;
          r.id   = frame_id;
          r.last = 1'b1;
          deframed_q = {deframed_q, r};
        end else begin
          bytes_left = hdr_len - HDR_BYTES;
          in_frame   = 1'b1;
        end
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      n_fail++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_win    = '{default: '0};
      hdr_fill   = '0;
      in_frame   = 1'b0;
      bytes_left = '0;
      frame_id   = '0;
      magic_q    = '0;
      version_q  = '0;
      deframed_q.delete();
      n_fail     = 0;
      n_results  = 0;
      n_drops    = 0;
      n_ends     = 0;
      fail_count_o   <= 0;
      pending_o      <= 0;
      result_count_o <= 0;
      drop_count_o   <= 0;
      end_count_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAGIC:   magic_q = cfg_wdata_i;
          REG_VERSION: version_q = cfg_wdata_i;
          default:     ;
        endcase
      end
      // Retire before predicting: no result may show up in the cycle of its byte
      if (res.valid && res.ready) begin
        n_results++;
        if (res.result_kind == KIND_DROP) n_drops++;
        if (res.frame_end) n_ends++;
        if (deframed_q.size() == 0) begin
          $display("%0t: result with none predicted, expected nothing, %s %0h %0h %0h",
                   $time, "actual kind/byte/id", res.result_kind, res.payload_byte,
                   res.request_id);
          n_fail++;
        end else begin
          want = deframed_q.pop_front();
          check_field("result_kind", want.kind, res.result_kind);
          check_field("payload_byte", want.data, res.payload_byte);
          check_field("request_id", want.id, res.request_id);
          check_field("frame_end", want.last, res.frame_end);
          check_field("drop_cause", want.cause, res.drop_cause);
        end
      end
      if (rx.valid && rx.ready) deframe_byte(rx.rx_byte);
      fail_count_o   <= n_fail;
      pending_o      <= deframed_q.size();
      result_count_o <= n_results;
      drop_count_o   <= n_drops;
      end_count_o    <= n_ends;
    end
  end

endmodule

/* verif/length_prefixed_frame_deframer_tb.sv */
module length_prefixed_frame_deframer_tb;
  import lpfd_pkg::*;

  localparam int unsigned     MAX_WAIT      = 13;
  localparam int unsigned     SETTLE_CYCLES = 8;    // idle margin after the last result
  localparam int unsigned     N_PHASES      = 5;
  localparam int unsigned     PHASE_ITEMS   = 115;
  localparam int unsigned     LONG_HOLD     = 200;
  localparam int unsigned     HOLD_AT_A     = 150;
  localparam int unsigned     HOLD_AT_B     = 450;
  localparam longint unsigned TIMEOUT_TICKS = 64'd2_000_000;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  lpfd_byte_if   byte_ch ();
  lpfd_result_if res_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned result_count;
  int unsigned drop_count;
  int unsigned end_count;

  // Register values currently loaded; good headers are built from these
  logic [7:0]  magic_cur   = '0;
  logic [7:0]  version_cur = '0;
  int unsigned tx_quiet    = 0;
  int unsigned rx_quiet    = 0;
  int unsigned n_sent      = 0;
  int unsigned n_settings  = 1;

  length_prefixed_frame_deframer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .rx          (byte_ch),
    .res         (res_ch)
  );

  lpfd_deframe_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .rx             (byte_ch),
    .res            (res_ch),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count),
    .drop_count_o   (drop_count),
    .end_count_o    (end_count)
  );

  always #5 clk_i = ~clk_i;

  // Idle cycles before the next transaction on one side. Mostly uniform over
  // 0..MAX_WAIT, with occasional runs of back-to-back transactions.
  function automatic int unsigned draw_wait(inout int unsigned quiet);
    int unsigned w;
    if (quiet > 0) begin
      quiet--;
      w = 0;
    end else if ($urandom_range(0, 24) == 0) begin
      quiet = $urandom_range(10, 40);
      w = 0;
    end else w = $urandom_range(0, MAX_WAIT);
    return w;
  endfunction

  // Offer one stream byte and hold it until the block takes it. Valid stays
  // high afterwards so a following byte with no gap streams without a bubble;
  // anything that pauses the stream must drop valid first (see drain).
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = draw_wait(tx_quiet);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
    n_sent++;
  endtask

  task automatic send_random_bytes(input int unsigned count);
    repeat (count) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Send the first `count` bytes of a header, most significant byte first
  task automatic send_header(input logic [31:0] len, input logic [7:0] mg,
                             input logic [7:0] vr, input logic [31:0] id,
                             input int unsigned count);
    logic [79:0] hdr;
    int unsigned i;
    hdr = {len, mg, vr, id};
    for (i = 0; i < count; i++) send_byte(hdr[79 - 8 * i -: 8]);
  endtask

  // Stop offering, wait for every predicted result, then let the block settle
  // in case the last bytes were header bytes that produce nothing.
  task automatic drain();
    byte_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write an unused index first (must be ignored), then both registers.
  // Keep the write enable high across the three writes.
  task automatic write_regs(input logic [7:0] mg, input logic [7:0] vr);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_IDX_W'($urandom_range(REG_VERSION + 1, (1 << CFG_IDX_W) - 1));
    cfg_wdata <= CFG_DATA_W'($urandom_range(0, 255));
    @(posedge clk_i);
    cfg_idx   <= REG_MAGIC;
    cfg_wdata <= mg;
    @(posedge clk_i);
    cfg_idx   <= REG_VERSION;
    cfg_wdata <= vr;
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    magic_cur   = mg;
    version_cur = vr;
    n_settings++;
  endtask

  // Result side: stall at random, and twice hold off for a long stretch so
  // the output buffer fills and the block pushes back on the stream.
  initial begin : sink_proc
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken == HOLD_AT_A || taken == HOLD_AT_B) stall = LONG_HOLD;
      else stall = draw_wait(rx_quiet);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      taken++;
    end
  end

  initial begin : stimulus
    logic [7:0]  magic_set [N_PHASES];
    logic [7:0]  version_set [N_PHASES];
    logic [31:0] len;
    logic [7:0]  mg;
    logic [7:0]  vr;
    int unsigned pick;
    int unsigned flips;
    int unsigned phase_start;
    int unsigned p;
    bit          paused;

    // Register settings per phase: extremes first, then random pairs
    magic_set   = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00};
    version_set = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00};
    magic_set[N_PHASES - 2]   = 8'($urandom_range(0, 255));
    version_set[N_PHASES - 2] = 8'($urandom_range(0, 255));
    magic_set[N_PHASES - 1]   = 8'($urandom_range(0, 255));
    version_set[N_PHASES - 1] = 8'($urandom_range(0, 255));

    byte_ch.valid   <= 1'b0;
    byte_ch.rx_byte <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run on the reset register values.
    // One-byte payload with all-ones id and data, then an empty frame with id 0.
    send_header(32'd11, magic_cur, version_cur, 32'hFFFF_FFFF, HDR_BYTES);
    send_byte(8'hFF);
    send_header(HDR_BYTES, magic_cur, version_cur, '0, HDR_BYTES);
    // Bad version with a legal length: drop for version. The next byte leaves
    // the inverted version at the magic slot, so the drop is for magic. The
    // byte after that lines up magic and version and leaves the length too
    // large: drop for length.
    send_header(HDR_BYTES, magic_cur, ~version_cur, '0, CHECK_AT);
    send_byte(magic_cur);
    send_byte(version_cur);

    // Random part: mostly well-formed frames with random content, the rest
    // broken headers and noise that force byte-by-byte resync.
    for (p = 0; p < N_PHASES; p++) begin
      drain();
      write_regs(magic_set[p], version_set[p]);
      phase_start = n_sent;
      paused      = 1'b0;
      while (n_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // good frame; payload mostly short, sometimes empty
          pick = $urandom_range(0, 9);
          len  = HDR_BYTES + ((pick < 2) ? 0 :
                              (pick < 9) ? $urandom_range(1, 16) : $urandom_range(17, 64));
          send_header(len, magic_cur, version_cur, $urandom(), HDR_BYTES);
          send_random_bytes(len - HDR_BYTES);
        end else if (pick < 80) begin
          // length out of range with good magic and version
          case ($urandom_range(0, 2))
            0:       len = $urandom_range(0, HDR_BYTES - 1);
            1:       len = DEF_MAX_FRAME + 1;
            default: len = $urandom_range(DEF_MAX_FRAME + 2, 32'hFFFF_FFFF);
          endcase
          send_header(len, magic_cur, version_cur, $urandom(),
                      $urandom_range(CHECK_AT, HDR_BYTES));
        end else if (pick < 90) begin
          // wrong magic, wrong version, or both
          flips = $urandom_range(1, 3);
          mg = flips[0] ? magic_cur ^ 8'($urandom_range(1, 255)) : magic_cur;
          vr = flips[1] ? version_cur ^ 8'($urandom_range(1, 255)) : version_cur;
          send_header(HDR_BYTES + $urandom_range(0, 16), mg, vr, $urandom(),
                      $urandom_range(CHECK_AT, HDR_BYTES));
        end else begin
          send_random_bytes($urandom_range(1, 8));
        end
        // Halfway through, pause the stream until every result is back
        if (!paused && n_sent - phase_start >= PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    $display("Covered %0d stream bytes over %0d register settings.", n_sent, n_settings);
    $display("Checked %0d results: %0d resync drops, %0d frame ends.",
             result_count, drop_count, end_count);
    if (pending != 0) $display("%0t: %0d predicted results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("length_prefixed_frame_deframer_tb passed");
    end else begin
      $display("length_prefixed_frame_deframer_tb failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin : watchdog
    #(TIMEOUT_TICKS);
    $display("length_prefixed_frame_deframer_tb failed");
    $finish;
  end

endmodule
